// ----- src/daap_pkg.sv -----
// Shared constants and types for the dual-axis attitude PID core.
// Used by the core and by its port checker; depends on nothing else.
package daap_pkg;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam int GAIN_W   = 18;
   localparam int CENTRE_W = 8;
   localparam int RAW_W    = 16;
   localparam int TIME_W   = 32;
   localparam int ANG_W    = 13;
   localparam int DRIVE_W  = 14;
   localparam int INTEG_W  = 25;
   localparam int COUNT_W  = 5;

   localparam int PID_PERIOD_MS = 40;
   localparam int ANG_LIMIT     = 2880;
   localparam int SPIKE_LIMIT   = 96;
   localparam int INTEG_WINDOW  = 32;
   localparam int SUM_LIMIT     = 8388608;
   localparam int ROUND_BIAS    = 32768;
   localparam int COUNT_MAX     = 21;
   localparam int SPIKE_START   = 20;
   localparam int DRIVE_MIN     = -128;
   localparam int DRIVE_MAX     = 4208;

   localparam logic [CSR_IDX_W-1:0] REG_KP_PITCH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KI_PITCH     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KD_PITCH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KP_ROLL      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KI_ROLL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KD_ROLL      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PITCH_CENTRE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_ROLL_CENTRE  = 3'd7;

   localparam logic [GAIN_W-1:0]   KP_PITCH_RST     = 18'd16384;
   localparam logic [GAIN_W-1:0]   KI_PITCH_RST     = 18'd66;
   localparam logic [GAIN_W-1:0]   KD_PITCH_RST     = 18'd819;
   localparam logic [GAIN_W-1:0]   KP_ROLL_RST      = 18'd16384;
   localparam logic [GAIN_W-1:0]   KI_ROLL_RST      = 18'd66;
   localparam logic [GAIN_W-1:0]   KD_ROLL_RST      = 18'd737;
   localparam logic [CENTRE_W-1:0] PITCH_CENTRE_RST = 8'd192;
   localparam logic [CENTRE_W-1:0] ROLL_CENTRE_RST  = 8'd129;

   typedef struct packed {
      logic signed [INTEG_W-1:0] integ;
      logic signed [DRIVE_W-1:0] drive;
   } pid_result_type;

endpackage

// ----- src/dual_axis_attitude_pid_core.sv -----
// Path: a word accepted on req goes to the input register, then to the result register,
// which presents it on rsp; the move waits while the rsp word is stalled.
// Throughput: one word per cycle; req_tready drops only while the rsp word is stalled.
// Reset (synchronous, active high) clears the angle history, sample count, integrators,
// update time stamp and held drives, and loads the gain and centre registers with defaults.
// Depends on daap_pkg for widths, limits and register indexes.
module dual_axis_attitude_pid_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pitch_raw[15:0], roll_raw[31:16], now_ms[63:32]
   input  logic [daap_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // pitch_drive[13:0], roll_drive[27:14], filtered_pitch[40:28],
   // filtered_roll[53:41], zero padding[55:54]
   output logic [daap_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // pid_updated[0]
   output logic [daap_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                                csr_we,
   input  logic [daap_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [daap_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [daap_pkg::GAIN_W-1:0]   kp_pitch_ff, ki_pitch_ff, kd_pitch_ff;
   logic [daap_pkg::GAIN_W-1:0]   kp_roll_ff, ki_roll_ff, kd_roll_ff;
   logic [daap_pkg::CENTRE_W-1:0] pitch_centre_ff, roll_centre_ff;

   logic                             in_valid_ff, in_valid_in;
   logic [daap_pkg::RAW_W-1:0]       in_pitch_ff, in_roll_ff;
   logic [daap_pkg::TIME_W-1:0]      in_now_ff;

   logic                             out_valid_ff, out_valid_in;
   logic [daap_pkg::RSP_DATA_W-1:0]  out_data_ff, out_data_in;
   logic                             out_upd_ff;

   logic signed [daap_pkg::ANG_W-1:0]   prev_pitch_ff, prev_roll_ff;
   logic [daap_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic signed [daap_pkg::INTEG_W-1:0] integ_pitch_ff, integ_roll_ff;
   logic [daap_pkg::TIME_W-1:0]         last_ms_ff;
   logic signed [daap_pkg::DRIVE_W-1:0] hold_pitch_ff, hold_roll_ff;
   logic signed [daap_pkg::DRIVE_W-1:0] hold_pitch_in, hold_roll_in;

   logic                                advance, fire, spike_on, upd;
   logic signed [daap_pkg::ANG_W-1:0]   filt_pitch, filt_roll;
   logic [daap_pkg::TIME_W-1:0]         elapsed;
   daap_pkg::pid_result_type            pitch_step, roll_step;

   function automatic logic signed [daap_pkg::ANG_W-1:0] filter_angle(
      input logic [daap_pkg::RAW_W-1:0]       raw,
      input logic signed [daap_pkg::ANG_W-1:0] prev,
      input logic                             spike_en
   );
      logic signed [daap_pkg::RAW_W:0]   ang;
      logic signed [daap_pkg::RAW_W+1:0] dif;
      logic signed [daap_pkg::ANG_W-1:0] res;
      ang = (daap_pkg::RAW_W+1)'(0) - $signed({raw[daap_pkg::RAW_W-1], raw});
      dif = $signed({ang[daap_pkg::RAW_W], ang})
          - $signed({{(daap_pkg::RAW_W+2-daap_pkg::ANG_W){prev[daap_pkg::ANG_W-1]}}, prev});
      if (spike_en && (dif > $signed((daap_pkg::RAW_W+2)'(daap_pkg::SPIKE_LIMIT)) ||
                       dif < $signed((daap_pkg::RAW_W+2)'(-daap_pkg::SPIKE_LIMIT)))) begin
         res = prev;
      end else if (ang > $signed((daap_pkg::RAW_W+1)'(daap_pkg::ANG_LIMIT)) ||
                   ang < $signed((daap_pkg::RAW_W+1)'(-daap_pkg::ANG_LIMIT))) begin
         res = prev;
      end else begin
         res = ang[daap_pkg::ANG_W-1:0];
      end
      return res;
   endfunction

   function automatic daap_pkg::pid_result_type pid_axis(
      input logic signed [daap_pkg::ANG_W-1:0]   ang,
      input logic signed [daap_pkg::ANG_W-1:0]   prev,
      input logic signed [daap_pkg::INTEG_W-1:0] integ,
      input logic [daap_pkg::GAIN_W-1:0]         kp,
      input logic [daap_pkg::GAIN_W-1:0]         ki,
      input logic [daap_pkg::GAIN_W-1:0]         kd,
      input logic [daap_pkg::CENTRE_W-1:0]       centre
   );
      logic signed [daap_pkg::ANG_W:0]     dif;
      logic signed [30:0]                  p_term;
      logic signed [31:0]                  d_term;
      logic signed [daap_pkg::INTEG_W:0]   i_term, i_sum;
      logic signed [daap_pkg::INTEG_W-1:0] i_new, s_clip;
      logic signed [33:0]                  total;
      logic signed [daap_pkg::INTEG_W:0]   rounded;
      logic signed [9:0]                   steps;
      daap_pkg::pid_result_type            res;
      dif = $signed({ang[daap_pkg::ANG_W-1], ang}) - $signed({prev[daap_pkg::ANG_W-1], prev});
      p_term = $signed({13'd0, kp}) * $signed({{18{ang[daap_pkg::ANG_W-1]}}, ang});
      d_term = $signed({14'd0, kd}) * $signed({{18{dif[daap_pkg::ANG_W]}}, dif});
      i_term = $signed({8'd0, ki}) * $signed({{13{ang[daap_pkg::ANG_W-1]}}, ang});
      i_sum  = $signed({integ[daap_pkg::INTEG_W-1], integ}) + i_term;
      if (ang > $signed(daap_pkg::ANG_W'(-daap_pkg::INTEG_WINDOW)) &&
          ang < $signed(daap_pkg::ANG_W'(daap_pkg::INTEG_WINDOW))) begin
         if (i_sum > $signed((daap_pkg::INTEG_W+1)'(daap_pkg::SUM_LIMIT))) begin
            i_new = $signed(daap_pkg::INTEG_W'(daap_pkg::SUM_LIMIT));
         end else if (i_sum < $signed((daap_pkg::INTEG_W+1)'(-daap_pkg::SUM_LIMIT))) begin
            i_new = $signed(daap_pkg::INTEG_W'(-daap_pkg::SUM_LIMIT));
         end else begin
            i_new = i_sum[daap_pkg::INTEG_W-1:0];
         end
      end else begin
         i_new = '0;
      end
      total = $signed({{3{p_term[30]}}, p_term})
            + $signed({{(34-daap_pkg::INTEG_W){i_new[daap_pkg::INTEG_W-1]}}, i_new})
            + $signed({{2{d_term[31]}}, d_term});
      if (total > $signed(34'(daap_pkg::SUM_LIMIT))) begin
         s_clip = $signed(daap_pkg::INTEG_W'(daap_pkg::SUM_LIMIT));
      end else if (total < $signed(34'(-daap_pkg::SUM_LIMIT))) begin
         s_clip = $signed(daap_pkg::INTEG_W'(-daap_pkg::SUM_LIMIT));
      end else begin
         s_clip = total[daap_pkg::INTEG_W-1:0];
      end
      rounded = $signed({s_clip[daap_pkg::INTEG_W-1], s_clip})
              + $signed((daap_pkg::INTEG_W+1)'(daap_pkg::ROUND_BIAS));
      steps = rounded[daap_pkg::INTEG_W:16];
      res.integ = i_new;
      res.drive = $signed({2'b00, centre, 4'b0000}) - $signed({{4{steps[9]}}, steps});
      return res;
   endfunction

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign fire       = in_valid_ff && advance;

   assign spike_on   = count_ff > daap_pkg::COUNT_W'(daap_pkg::SPIKE_START);
   assign filt_pitch = filter_angle(in_pitch_ff, prev_pitch_ff, spike_on);
   assign filt_roll  = filter_angle(in_roll_ff, prev_roll_ff, spike_on);
   assign elapsed    = in_now_ff - last_ms_ff;
   assign upd        = elapsed > daap_pkg::TIME_W'(daap_pkg::PID_PERIOD_MS);

   assign pitch_step = pid_axis(filt_pitch, prev_pitch_ff, integ_pitch_ff,
                                kp_pitch_ff, ki_pitch_ff, kd_pitch_ff, pitch_centre_ff);
   assign roll_step  = pid_axis(filt_roll, prev_roll_ff, integ_roll_ff,
                                kp_roll_ff, ki_roll_ff, kd_roll_ff, roll_centre_ff);

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      count_in = count_ff;
      if (count_ff < daap_pkg::COUNT_W'(daap_pkg::COUNT_MAX)) begin
         count_in = count_ff + daap_pkg::COUNT_W'(1);
      end
      hold_pitch_in = upd ? pitch_step.drive : hold_pitch_ff;
      hold_roll_in  = upd ? roll_step.drive : hold_roll_ff;
      out_data_in   = {2'b00, filt_roll, filt_pitch, hold_roll_in, hold_pitch_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_pitch_ff     <= daap_pkg::KP_PITCH_RST;
         ki_pitch_ff     <= daap_pkg::KI_PITCH_RST;
         kd_pitch_ff     <= daap_pkg::KD_PITCH_RST;
         kp_roll_ff      <= daap_pkg::KP_ROLL_RST;
         ki_roll_ff      <= daap_pkg::KI_ROLL_RST;
         kd_roll_ff      <= daap_pkg::KD_ROLL_RST;
         pitch_centre_ff <= daap_pkg::PITCH_CENTRE_RST;
         roll_centre_ff  <= daap_pkg::ROLL_CENTRE_RST;
      end else if (csr_we) begin
         case (csr_index)
            daap_pkg::REG_KP_PITCH:     kp_pitch_ff     <= csr_wdata;
            daap_pkg::REG_KI_PITCH:     ki_pitch_ff     <= csr_wdata;
            daap_pkg::REG_KD_PITCH:     kd_pitch_ff     <= csr_wdata;
            daap_pkg::REG_KP_ROLL:      kp_roll_ff      <= csr_wdata;
            daap_pkg::REG_KI_ROLL:      ki_roll_ff      <= csr_wdata;
            daap_pkg::REG_KD_ROLL:      kd_roll_ff      <= csr_wdata;
            daap_pkg::REG_PITCH_CENTRE: pitch_centre_ff <= csr_wdata[daap_pkg::CENTRE_W-1:0];
            daap_pkg::REG_ROLL_CENTRE:  roll_centre_ff  <= csr_wdata[daap_pkg::CENTRE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         prev_pitch_ff  <= '0;
         prev_roll_ff   <= '0;
         count_ff       <= '0;
         integ_pitch_ff <= '0;
         integ_roll_ff  <= '0;
         last_ms_ff     <= '0;
         hold_pitch_ff  <= '0;
         hold_roll_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            prev_pitch_ff <= filt_pitch;
            prev_roll_ff  <= filt_roll;
            count_ff      <= count_in;
            hold_pitch_ff <= hold_pitch_in;
            hold_roll_ff  <= hold_roll_in;
            if (upd) begin
               last_ms_ff     <= in_now_ff;
               integ_pitch_ff <= pitch_step.integ;
               integ_roll_ff  <= roll_step.integ;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_pitch_ff <= req_tdata[15:0];
         in_roll_ff  <= req_tdata[31:16];
         in_now_ff   <= req_tdata[63:32];
      end
      if (fire) begin
         out_data_ff <= out_data_in;
         out_upd_ff  <= upd;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_upd_ff;

endmodule

// ----- src/daap_checker.sv -----
// Port-level checker for the dual-axis attitude PID core, bound to the top level.
// Depends on daap_pkg for field widths and output ranges.
module daap_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [daap_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [daap_pkg::RSP_USER_W-1:0]  rsp_tuser
);

   logic [daap_pkg::DRIVE_W-1:0] seen_pitch_ff, seen_roll_ff;
   logic                         rsp_take;

   assign rsp_take = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_pitch_ff <= '0;
         seen_roll_ff  <= '0;
      end else if (rsp_take && rsp_tuser[0]) begin
         seen_pitch_ff <= rsp_tdata[13:0];
         seen_roll_ff  <= rsp_tdata[27:14];
      end
   end

   // A word without a fresh update must repeat the drives last delivered.
   held_drives: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_tuser[0] |->
         rsp_tdata[13:0] == seen_pitch_ff && rsp_tdata[27:14] == seen_roll_ff)
      else $error("held drive changed without an update");

   angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[40:28]) <= $signed(13'(daap_pkg::ANG_LIMIT)) &&
         $signed(rsp_tdata[40:28]) >= $signed(13'(-daap_pkg::ANG_LIMIT)) &&
         $signed(rsp_tdata[53:41]) <= $signed(13'(daap_pkg::ANG_LIMIT)) &&
         $signed(rsp_tdata[53:41]) >= $signed(13'(-daap_pkg::ANG_LIMIT)))
      else $error("filtered angle out of range");

   drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         $signed(rsp_tdata[13:0]) <= $signed(14'(daap_pkg::DRIVE_MAX)) &&
         $signed(rsp_tdata[13:0]) >= $signed(14'(daap_pkg::DRIVE_MIN)) &&
         $signed(rsp_tdata[27:14]) <= $signed(14'(daap_pkg::DRIVE_MAX)) &&
         $signed(rsp_tdata[27:14]) >= $signed(14'(daap_pkg::DRIVE_MIN)))
      else $error("drive out of range");

   stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled word changed");

endmodule

bind dual_axis_attitude_pid_core daap_checker u_daap_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
